[rtl/search_transposition_table_core_macros.svh]
// assertion macros shared by the transposition table rtl
`ifndef SEARCH_TRANSPOSITION_TABLE_CORE_MACROS_SVH
`define SEARCH_TRANSPOSITION_TABLE_CORE_MACROS_SVH
`ifndef SYNTH
// checked while reset is low
`define STT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("transposition table assertion failed");
// checked at every edge, reset included
`define STT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("transposition table assertion failed");
`else
`define STT_ASSERT(label, clk, rst, prop)
`define STT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[rtl/stt_pkg.sv]
// types and constants of the transposition table
package stt_pkg;

   // table geometry, entry count is a power of two
   localparam int TABLE_ENTRIES = 65536;
   localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);
   localparam int MAX_PLY       = 64;
   localparam int MOVE_BITS     = 32;
   localparam int PLY_BITS      = 6;
   localparam int DEPTH_BITS    = 6;
   localparam int FILL_BITS     = 17;
   localparam int THR_BITS      = 15;

   localparam logic [FILL_BITS-1:0] FILL_MAX   = 17'd65536;
   localparam logic [THR_BITS-1:0]  MATE_RESET = 15'd29936;

   // operation codes
   localparam logic OP_PROBE = 1'b0;
   localparam logic OP_STORE = 1'b1;

   // bound kinds
   localparam logic [1:0] BOUND_EXACT = 2'd0;
   localparam logic [1:0] BOUND_UPPER = 2'd1;
   localparam logic [1:0] BOUND_LOWER = 2'd2;

   typedef struct packed {
      logic                  opcode;
      logic [63:0]           position_key;
      logic [31:0]           move_word;
      logic signed [15:0]    score_in;
      logic [1:0]            bound_kind;
      logic [DEPTH_BITS-1:0] search_depth;
      logic signed [15:0]    alpha_bound;
      logic signed [15:0]    beta_bound;
      logic [PLY_BITS-1:0]   ply;
   } req_type;

   typedef struct packed {
      logic                 key_match;
      logic                 cutoff;
      logic [31:0]          stored_move;
      logic signed [15:0]   result_score;
      logic                 slot_was_empty;
      logic [FILL_BITS-1:0] filled_slots;
   } rsp_type;

   // one table slot
   typedef struct packed {
      logic [63:0]           key;
      logic [MOVE_BITS-1:0]  move;
      logic signed [15:0]    score;
      logic [DEPTH_BITS-1:0] depth;
      logic [1:0]            bound;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } sts_type;

endpackage

[rtl/stt_ram.sv]
// generic single write port ram with registered read
module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/stt_control.sv]
// sequencer for clearing, lookup and write back
`include "search_transposition_table_core_macros.svh"
module stt_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stt_pkg::sts_type sts,
   output stt_pkg::cmd_type cmd
);
   import stt_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // commands
   always_comb begin
      cmd          = '0;
      cmd.clear_wr = (state_ff == ST_CLEAR);
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.finish   = (state_ff == ST_LOOKUP) && sts.out_free;
   end

   assign req_stall = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `STT_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (state_ff == ST_CLEAR))
   `STT_ASSERT(a_accept_looks_up, clock, reset,
      (req_valid && !req_stall) |=> (state_ff == ST_LOOKUP))
   `STT_ASSERT(a_no_accept_in_clear, clock, reset, (state_ff == ST_CLEAR) |-> req_stall)
   `STT_ASSERT(a_finish_needs_room, clock, reset, cmd.finish |-> sts.out_free)

endmodule

[rtl/stt_datapath.sv]
// table memory, score adjustment, probe evaluation and result register
`include "search_transposition_table_core_macros.svh"
module stt_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  stt_pkg::req_type             req_data,
   input  logic                         csr_wr_en,
   input  logic [stt_pkg::THR_BITS-1:0] csr_wr_data,
   input  stt_pkg::cmd_type             cmd,
   output stt_pkg::sts_type             sts,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output stt_pkg::rsp_type             rsp_data
);
   import stt_pkg::*;

   localparam logic signed [17:0] SAT_HI = 18'sd32767;
   localparam logic signed [17:0] SAT_LO = -18'sd32768;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > SAT_HI) begin
         r = 16'sh7fff;
      end else if (v < SAT_LO) begin
         r = -16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

   logic [THR_BITS-1:0]   thr_ff;
   logic [INDEX_BITS-1:0] clear_addr_ff;
   logic [FILL_BITS-1:0]  fill_ff;
   logic [FILL_BITS-1:0]  fill_in;
   req_type               req_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   logic                  ram_wr_en;
   logic [INDEX_BITS-1:0] ram_wr_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data;
   logic [ENTRY_BITS-1:0] ram_rd_data;
   entry_type             rd_entry;
   entry_type             new_entry;

   logic                  is_store;
   logic                  slot_empty;
   logic [PLY_BITS-1:0]   ply_eff;
   logic signed [16:0]    thr_s;
   logic signed [16:0]    neg_thr_s;
   logic signed [17:0]    ply_s;
   logic signed [17:0]    in_score_s;
   logic signed [17:0]    st_score_s;
   logic signed [15:0]    store_score;
   logic signed [15:0]    probe_score;
   logic                  probe_match;
   logic                  deep_enough;
   logic                  probe_cut;
   logic signed [15:0]    probe_res;

   // mate threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= MATE_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // clearing sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   // request holding register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // table memory
   assign rd_entry    = entry_type'(ram_rd_data);
   assign ram_wr_en   = cmd.clear_wr || (cmd.finish && is_store);
   assign ram_wr_addr = cmd.clear_wr ? clear_addr_ff : req_ff.position_key[INDEX_BITS-1:0];
   assign ram_wr_data = cmd.clear_wr ? '0 : ENTRY_BITS'(new_entry);

   stt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (req_data.position_key[INDEX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   // common operands
   assign is_store   = (req_ff.opcode == OP_STORE);
   assign slot_empty = (rd_entry.key == 64'd0);
   assign ply_eff    = (int'(req_ff.ply) >= MAX_PLY) ? PLY_BITS'(MAX_PLY - 1) : req_ff.ply;
   assign thr_s      = signed'({2'b00, thr_ff});
   assign neg_thr_s  = -thr_s;
   assign ply_s      = signed'({{(18-PLY_BITS){1'b0}}, ply_eff});
   assign in_score_s = {{2{req_ff.score_in[15]}}, req_ff.score_in};
   assign st_score_s = {{2{rd_entry.score[15]}}, rd_entry.score};

   // store: mate scores move to distance from this node
   always_comb begin
      store_score = req_ff.score_in;
      if (in_score_s > 18'(thr_s)) begin
         store_score = sat16(in_score_s + ply_s);
      end else if (in_score_s < 18'(neg_thr_s)) begin
         store_score = sat16(in_score_s - ply_s);
      end
   end

   always_comb begin
      new_entry       = '0;
      new_entry.key   = req_ff.position_key;
      new_entry.move  = MOVE_BITS'(req_ff.move_word);
      new_entry.score = store_score;
      new_entry.depth = req_ff.search_depth;
      new_entry.bound = req_ff.bound_kind;
   end

   // probe: undo the mate adjustment
   always_comb begin
      probe_score = rd_entry.score;
      if (st_score_s > 18'(thr_s)) begin
         probe_score = sat16(st_score_s - ply_s);
      end else if (st_score_s < 18'(neg_thr_s)) begin
         probe_score = sat16(st_score_s + ply_s);
      end
   end

   // probe: cutoff verdict from the bound kind
   assign probe_match = (rd_entry.key == req_ff.position_key);
   assign deep_enough = (rd_entry.depth >= req_ff.search_depth);

   always_comb begin
      probe_cut = 1'b0;
      probe_res = '0;
      case (rd_entry.bound)
         BOUND_EXACT: begin
            probe_cut = 1'b1;
            probe_res = probe_score;
         end
         BOUND_UPPER: begin
            if (probe_score <= req_ff.alpha_bound) begin
               probe_cut = 1'b1;
               probe_res = req_ff.alpha_bound;
            end
         end
         BOUND_LOWER: begin
            if (probe_score >= req_ff.beta_bound) begin
               probe_cut = 1'b1;
               probe_res = req_ff.beta_bound;
            end
         end
         default: begin
            probe_cut = 1'b0;
         end
      endcase
   end

   // fill count, saturating
   always_comb begin
      fill_in = fill_ff;
      if (cmd.finish && is_store && slot_empty && (fill_ff < FILL_MAX)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // result assembly
   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.filled_slots = fill_in;
      if (is_store) begin
         rsp_data_in.slot_was_empty = slot_empty;
      end else if (probe_match) begin
         rsp_data_in.key_match   = 1'b1;
         rsp_data_in.stored_move = 32'(rd_entry.move);
         if (deep_enough && probe_cut) begin
            rsp_data_in.cutoff       = 1'b1;
            rsp_data_in.result_score = probe_res;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // status
   always_comb begin
      sts            = '0;
      sts.clear_last = (clear_addr_ff == INDEX_BITS'(TABLE_ENTRIES - 1));
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `STT_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (fill_ff == '0 && !rsp_valid_ff))
   `STT_ASSERT(a_fill_bounded, clock, reset, fill_ff <= FILL_MAX)
   `STT_ASSERT(a_cut_needs_match, clock, reset,
      rsp_valid_ff |-> (!rsp_data_ff.cutoff || rsp_data_ff.key_match))
   `STT_ASSERT(a_empty_only_on_store, clock, reset,
      rsp_valid_ff |-> !(rsp_data_ff.slot_was_empty && rsp_data_ff.key_match))

endmodule

[rtl/search_transposition_table_core.sv]
// top level of the direct-mapped always-replace transposition table
// After reset the block sweeps its 65536-slot table to zero, one slot per
// cycle, with req_stall high until the sweep ends; mate_threshold writes
// are taken during that time. Then each request first reads its slot
// synchronously from the single table memory, then evaluates the probe or
// adjusts the score and writes the slot back, which loads the result
// register; this waits while that register holds a stalled result.
// No new request is taken until the last is written back; a finished result
// waits in the output register without blocking acceptance of the next one.
module search_transposition_table_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  stt_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output stt_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [stt_pkg::THR_BITS-1:0] csr_wr_data
);
   import stt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   stt_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table and evaluation
   stt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule
